### hdl/adsr_pkg.sv
// types, codes and reset values shared by the envelope generator files
// no dependencies; compiled first
package adsr_pkg;

	// request codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	// internal envelope stage held in the phase code register
	localparam logic [1:0] PC_NONE    = 2'd0;
	localparam logic [1:0] PC_SUSTAIN = 2'd1;
	localparam logic [1:0] PC_DECAY   = 2'd2;
	localparam logic [1:0] PC_ATTACK  = 2'd3;

	// reported phase
	localparam logic [2:0] PH_OFF     = 3'd0;
	localparam logic [2:0] PH_PENDING = 3'd1;
	localparam logic [2:0] PH_ATTACK  = 3'd2;
	localparam logic [2:0] PH_DECAY   = 3'd3;
	localparam logic [2:0] PH_SUSTAIN = 3'd4;
	localparam logic [2:0] PH_RELEASE = 3'd5;
	localparam logic [2:0] PH_ECHO    = 3'd6;

	// register map, index = byte address / 4
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_DECAY   = 3'd1;
	localparam logic [2:0] REG_SUSTAIN = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_ECHO_VOL = 3'd4;
	localparam logic [2:0] REG_ECHO_LEN = 3'd5;

	localparam logic [7:0] LEVEL_MAX = 8'hFF;

	localparam logic [7:0] RST_ATTACK  = 8'hFF;
	localparam logic [7:0] RST_DECAY   = 8'h00;
	localparam logic [7:0] RST_SUSTAIN = 8'hFF;
	localparam logic [7:0] RST_RELEASE = 8'h00;
	localparam logic [7:0] RST_ECHO_VOL = 8'h00;
	localparam logic [7:0] RST_ECHO_LEN = 8'h00;

	typedef struct packed {
		logic [7:0] attack_rate;
		logic [7:0] decay_factor;
		logic [7:0] sustain_level;
		logic [7:0] release_factor;
		logic [7:0] echo_volume;
		logic [7:0] echo_length;
	} cfg_t;

	typedef struct packed {
		logic       active;
		logic [7:0] level;
		logic [2:0] phase;
		logic       looping;
	} res_t;

	typedef struct packed {
		logic       start_pending;
		logic       stop_pending;
		logic       echo_active;
		logic       loop_mark;
		logic [1:0] phase_code;
		logic [7:0] level;
		logic [7:0] echo_counter;
	} env_state_t;

endpackage

### hdl/adsr_if.sv
// request channels of the envelope generator: command in, result out
// no package dependency; valid/ready handshake with source and sink modports
interface adsr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       wave_loops;

	modport source (output valid, func, wave_loops, input ready);
	modport sink (input valid, func, wave_loops, output ready);
endinterface

interface adsr_env_if;
	logic       valid;
	logic       ready;
	logic       active;
	logic [7:0] level;
	logic [2:0] phase;
	logic       looping;

	modport source (output valid, active, level, phase, looping, input ready);
	modport sink (input valid, active, level, phase, looping, output ready);
endinterface

### hdl/adsr_regs.sv
// apb configuration registers of the envelope generator
// depends on adsr_pkg
module adsr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output adsr_pkg::cfg_t                cfg
);
	import adsr_pkg::*;

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_rate    <= RST_ATTACK;
			cfg_q.decay_factor   <= RST_DECAY;
			cfg_q.sustain_level  <= RST_SUSTAIN;
			cfg_q.release_factor <= RST_RELEASE;
			cfg_q.echo_volume    <= RST_ECHO_VOL;
			cfg_q.echo_length    <= RST_ECHO_LEN;
		end else if (wr) begin
			case (idx)
				REG_ATTACK:   cfg_q.attack_rate    <= pwdata[7:0];
				REG_DECAY:    cfg_q.decay_factor   <= pwdata[7:0];
				REG_SUSTAIN:  cfg_q.sustain_level  <= pwdata[7:0];
				REG_RELEASE:  cfg_q.release_factor <= pwdata[7:0];
				REG_ECHO_VOL: cfg_q.echo_volume    <= pwdata[7:0];
				REG_ECHO_LEN: cfg_q.echo_length    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		case (idx)
			REG_ATTACK:   prdata = {24'd0, cfg_q.attack_rate};
			REG_DECAY:    prdata = {24'd0, cfg_q.decay_factor};
			REG_SUSTAIN:  prdata = {24'd0, cfg_q.sustain_level};
			REG_RELEASE:  prdata = {24'd0, cfg_q.release_factor};
			REG_ECHO_VOL: prdata = {24'd0, cfg_q.echo_volume};
			REG_ECHO_LEN: prdata = {24'd0, cfg_q.echo_length};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

### hdl/adsr_core.sv
// envelope state registers and the single-pass next-state logic
// depends on adsr_pkg
module adsr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [1:0]       func,
	input  logic             wave_loops,
	input  adsr_pkg::cfg_t   cfg,
	output adsr_pkg::res_t   result
);
	import adsr_pkg::*;

	env_state_t  s_q;
	env_state_t  n;
	logic [7:0]  factor;
	logic [15:0] prod;
	logic [7:0]  scaled;
	logic [8:0]  att_sum;
	logic [7:0]  cnt_dec;
	logic        busy;
	logic [2:0]  ph;

	// shared scaler: release while stop pending, decay otherwise
	assign factor  = s_q.stop_pending ? cfg.release_factor : cfg.decay_factor;
	assign prod    = 16'(s_q.level) * 16'(factor);
	assign scaled  = prod[15:8];
	assign att_sum = {1'b0, s_q.level} + {1'b0, cfg.attack_rate};
	assign cnt_dec = s_q.echo_counter - 8'd1;
	assign busy    = s_q.start_pending || s_q.stop_pending || s_q.echo_active
		|| (s_q.phase_code != PC_NONE);

	// next state for one request
	always_comb begin
		n = s_q;
		case (func)
			FUNC_TICK: begin
				if (s_q.start_pending) begin
					if (s_q.stop_pending) begin
						n.start_pending = 1'b0;
						n.stop_pending  = 1'b0;
						n.echo_active   = 1'b0;
						n.loop_mark     = 1'b0;
						n.phase_code    = PC_NONE;
					end else begin
						// attack from zero cannot overflow on its first step
						n.start_pending = 1'b0;
						n.phase_code    = PC_ATTACK;
						n.level         = cfg.attack_rate;
						n.echo_counter  = cfg.echo_length;
					end
				end else if (s_q.echo_active) begin
					n.echo_counter = cnt_dec;
					if (cnt_dec == 8'd0) begin
						n.stop_pending = 1'b0;
						n.echo_active  = 1'b0;
						n.loop_mark    = 1'b0;
						n.phase_code   = PC_NONE;
					end
				end else if (s_q.stop_pending) begin
					n.level = scaled;
					if (scaled <= cfg.echo_volume) begin
						if (cfg.echo_volume == 8'd0) begin
							n.stop_pending = 1'b0;
							n.loop_mark    = 1'b0;
							n.phase_code   = PC_NONE;
						end else begin
							n.echo_active = 1'b1;
						end
					end
				end else if (s_q.phase_code == PC_ATTACK) begin
					if (att_sum[8]) begin
						n.level      = LEVEL_MAX;
						n.phase_code = PC_DECAY;
					end else begin
						n.level = att_sum[7:0];
					end
				end else if (s_q.phase_code == PC_DECAY) begin
					n.level = scaled;
					if (scaled <= cfg.sustain_level) begin
						if (cfg.sustain_level != 8'd0) begin
							n.level      = cfg.sustain_level;
							n.phase_code = PC_SUSTAIN;
						end else if (cfg.echo_volume == 8'd0) begin
							n.loop_mark  = 1'b0;
							n.phase_code = PC_NONE;
						end else begin
							n.echo_active = 1'b1;
						end
					end
				end
			end
			FUNC_START: begin
				n.start_pending = 1'b1;
				n.stop_pending  = 1'b0;
				n.echo_active   = 1'b0;
				n.phase_code    = PC_NONE;
				n.loop_mark     = wave_loops;
			end
			FUNC_STOP: begin
				if (busy) begin
					n.stop_pending = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// reported phase of the new state
	always_comb begin
		if (n.start_pending) begin
			ph = PH_PENDING;
		end else if (n.echo_active) begin
			ph = PH_ECHO;
		end else if (n.stop_pending) begin
			ph = PH_RELEASE;
		end else begin
			case (n.phase_code)
				PC_ATTACK:  ph = PH_ATTACK;
				PC_DECAY:   ph = PH_DECAY;
				PC_SUSTAIN: ph = PH_SUSTAIN;
				default:    ph = PH_OFF;
			endcase
		end
	end

	assign result.active  = (ph != PH_OFF) && (ph != PH_PENDING);
	assign result.level   = n.level;
	assign result.phase   = ph;
	assign result.looping = n.loop_mark;

	// state update once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else if (en) begin
			s_q <= n;
		end
	end

	// pending start and echo tail never coexist
	a_start_echo: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_q.start_pending && s_q.echo_active))
		else $error("start pending while echo tail active");

	// an accepted start request leaves the start pending
	a_start_latch: assert property (@(posedge clk) disable iff (!arst_n)
		en && (func == FUNC_START) |=> s_q.start_pending)
		else $error("start request not latched");

	// a tick on a silent channel keeps the level
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		en && (func == FUNC_TICK) && !busy |=> $stable(s_q.level))
		else $error("level moved on an off channel");

	// each echo tick counts the tail down by one
	a_echo_count: assert property (@(posedge clk) disable iff (!arst_n)
		en && (func == FUNC_TICK) && s_q.echo_active && !s_q.start_pending
		|=> s_q.echo_counter == $past(s_q.echo_counter) - 8'd1)
		else $error("echo counter did not step");

endmodule

### hdl/adsr_envelope_with_echo_tail.sv
// top level of the envelope generator with echo tail
// depends on adsr_pkg, adsr_if, adsr_regs and adsr_core
//
// One command request (tick, note start or note stop) is taken every clock
// cycle unless the result side stalls; each gives exactly one result request
// with the channel's phase, level, activity and loop mark after the command.
// A command passes an input register and then the next-state logic (one 8x8
// multiply for the decay and release scaling) into the result register. The
// input register takes a new command while the previous result still waits.
// Registers are written over the apb port at byte address 4*i; the user must
// write them only while no command is in flight; the block does not enforce it.
module adsr_envelope_with_echo_tail (
	input  logic                          clk,
	input  logic                          arst_n,
	adsr_cmd_if.sink                      cmd,
	adsr_env_if.source                    env,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import adsr_pkg::*;

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       valid_s1;
	logic [1:0] func_s1;
	logic       wave_loops_s1;
	logic       out_valid_q;
	logic       advance;

	adsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adsr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.func       (func_s1),
		.wave_loops (wave_loops_s1),
		.cfg        (cfg),
		.result     (res)
	);

	// handshake between input and result registers
	assign advance   = valid_s1 && (!out_valid_q || env.ready);
	assign cmd.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1       <= cmd.func;
			wave_loops_s1 <= cmd.wave_loops;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (env.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign env.valid   = out_valid_q;
	assign env.active  = res_q.active;
	assign env.level   = res_q.level;
	assign env.phase   = res_q.phase;
	assign env.looping = res_q.looping;

	// a finished request moves on only into a free or draining result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !env.ready |-> !advance)
		else $error("result overwritten while stalled");

	// every processed command shows a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed command gave no result");

	// the input stage can always drain when the output is free
	a_input_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |-> advance && cmd.ready)
		else $error("input stage stuck with free output");

endmodule

### sim/adsr_envelope_with_echo_tail_test.sv
// self-checking testbench for the envelope generator with echo tail
// depends on adsr_pkg, adsr_if and adsr_envelope_with_echo_tail
// drives tick, start and stop requests plus apb register writes; a class predicts every result
module adsr_envelope_with_echo_tail_test;
	import adsr_pkg::*;

	// the spare request code, which leaves the channel as it is
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int PHASE_ITEMS = 100;
	localparam int N_SETTINGS = 9;
	localparam int SETTLE = 4;
	localparam int LONG_TAIL = 300;
	localparam int SHORT_TAIL = 40;
	// limit on cycles without a handshake, which a healthy run never reaches
	localparam int QUIET_LIMIT = 1000;

	// channel predictor and queue of expected envelope results
	class envelope_tracker;
		cfg_t regs;
		env_state_t st;
		res_t due[$];
		int mismatches;
		int compared;
		bit [7:0] phases_seen;

		function new();
			regs = '{attack_rate: RST_ATTACK, decay_factor: RST_DECAY,
				sustain_level: RST_SUSTAIN, release_factor: RST_RELEASE,
				echo_volume: RST_ECHO_VOL, echo_length: RST_ECHO_LEN};
			st = '0;
			mismatches = 0;
			compared = 0;
			phases_seen = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_ATTACK:   regs.attack_rate = value[7:0];
				REG_DECAY:    regs.decay_factor = value[7:0];
				REG_SUSTAIN:  regs.sustain_level = value[7:0];
				REG_RELEASE:  regs.release_factor = value[7:0];
				REG_ECHO_VOL: regs.echo_volume = value[7:0];
				REG_ECHO_LEN: regs.echo_length = value[7:0];
				default: ;
			endcase
		endfunction

		function bit sounding();
			return st.start_pending || st.stop_pending || st.echo_active ||
				st.phase_code != PC_NONE;
		endfunction

		// level is left where it is
		function void power_down();
			st.start_pending = 1'b0;
			st.stop_pending = 1'b0;
			st.echo_active = 1'b0;
			st.loop_mark = 1'b0;
			st.phase_code = PC_NONE;
		endfunction

		function logic [7:0] scaled(logic [7:0] lvl, logic [7:0] factor);
			logic [15:0] prod;
			prod = lvl * factor;
			return prod[15:8];
		endfunction

		// saturating add, carry out ends the attack
		function void attack_step();
			logic [8:0] sum;
			sum = {1'b0, st.level} + {1'b0, regs.attack_rate};
			if (sum[8]) begin
				st.level = LEVEL_MAX;
				st.phase_code = PC_DECAY;
			end else begin
				st.level = sum[7:0];
			end
		endfunction

		function void echo_or_off();
			if (regs.echo_volume == 8'h00)
				power_down();
			else
				st.echo_active = 1'b1;
		endfunction

		function void tick();
			if (st.start_pending) begin
				if (st.stop_pending) begin
					power_down();
					return;
				end
				st.start_pending = 1'b0;
				st.phase_code = PC_ATTACK;
				st.level = 8'h00;
				st.echo_counter = regs.echo_length;
				attack_step();
				return;
			end
			// echo tail counts down, a zero count wraps round
			if (st.echo_active) begin
				st.echo_counter = st.echo_counter - 8'd1;
				if (st.echo_counter == 8'h00)
					power_down();
				return;
			end
			if (st.stop_pending) begin
				st.level = scaled(st.level, regs.release_factor);
				if (st.level <= regs.echo_volume)
					echo_or_off();
				return;
			end
			if (st.phase_code == PC_ATTACK) begin
				attack_step();
			end else if (st.phase_code == PC_DECAY) begin
				st.level = scaled(st.level, regs.decay_factor);
				if (st.level <= regs.sustain_level) begin
					if (regs.sustain_level == 8'h00) begin
						echo_or_off();
					end else begin
						st.level = regs.sustain_level;
						st.phase_code = PC_SUSTAIN;
					end
				end
			end
		endfunction

		function logic [2:0] shown_phase();
			if (st.start_pending)
				return PH_PENDING;
			if (st.echo_active)
				return PH_ECHO;
			if (st.stop_pending)
				return PH_RELEASE;
			case (st.phase_code)
				PC_ATTACK:  return PH_ATTACK;
				PC_DECAY:   return PH_DECAY;
				PC_SUSTAIN: return PH_SUSTAIN;
				default:    return PH_OFF;
			endcase
		endfunction

		// accepted request: advance the channel and queue its result
		function void take_command(logic [1:0] func, logic loops);
			res_t want;
			logic [2:0] ph;
			case (func)
				FUNC_TICK: tick();
				FUNC_START: begin
					st.start_pending = 1'b1;
					st.stop_pending = 1'b0;
					st.echo_active = 1'b0;
					st.phase_code = PC_NONE;
					st.loop_mark = loops;
				end
				FUNC_STOP: if (sounding()) st.stop_pending = 1'b1;
				default: ;
			endcase
			ph = shown_phase();
			phases_seen[ph] = 1'b1;
			want.active = (ph >= PH_ATTACK);
			want.level = st.level;
			want.phase = ph;
			want.looping = st.loop_mark;
			due.push_back(want);
		endfunction

		function void report(string what, res_t want, res_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s at result %0d: expected active=%0b level=%0d phase=%0d looping=%0b",
					what, compared, want.active, want.level, want.phase, want.looping);
				$display("    got active=%0b level=%0d phase=%0d looping=%0b",
					got.active, got.level, got.phase, got.looping);
			end
		endfunction

		function void match_result(res_t got);
			res_t want;
			if (due.size() == 0) begin
				report("result with nothing expected", '0, got);
				return;
			end
			want = due.pop_front();
			compared++;
			if (got.active !== want.active || got.level !== want.level ||
				got.phase !== want.phase || got.looping !== want.looping)
				report("mismatch", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	adsr_cmd_if cmd_ch();
	adsr_env_if env_ch();

	envelope_tracker tracker = new();
	bit steady;
	int sent;
	int settings_used;

	adsr_envelope_with_echo_tail dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.env(env_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one request, after a random gap unless this setting runs without idling
	task automatic issue(input logic [1:0] func, input logic loops);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= func;
		cmd_ch.wave_loops <= loops;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		tracker.take_command(func, loops);
		sent++;
	endtask

	task automatic ticks(input int n);
		repeat (n) issue(FUNC_TICK, 1'($urandom_range(0, 1)));
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom()), value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.write_reg(idx, pwdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// new register setting, only once the block has gone quiet
	task automatic load_regs(input logic [7:0] atk, input logic [7:0] dec,
		input logic [7:0] sus, input logic [7:0] rel, input logic [7:0] evol,
		input logic [7:0] elen);
		drain();
		repeat (SETTLE) @(posedge clk);
		reg_write(REG_ATTACK, atk);
		reg_write(REG_DECAY, dec);
		reg_write(REG_SUSTAIN, sus);
		reg_write(REG_RELEASE, rel);
		reg_write(REG_ECHO_VOL, evol);
		reg_write(REG_ECHO_LEN, elen);
		settings_used++;
	endtask

	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return LEVEL_MAX;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// result side: random stall before each result
	initial begin
		int stall;
		res_t got;
		env_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				env_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			env_ch.ready <= 1'b1;
			@(posedge clk);
			while (!env_ch.valid) @(posedge clk);
			got.active = env_ch.active;
			got.level = env_ch.level;
			got.phase = env_ch.phase;
			got.looping = env_ch.looping;
			tracker.match_result(got);
		end
	end

	// watchdog on cycles with no handshake of any kind
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (env_ch.valid && env_ch.ready) ||
				(psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles, %0d results still due", QUIET_LIMIT,
			tracker.due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int start_count;
		int hold;
		bit full;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_TICK;
		cmd_ch.wave_loops = 1'b0;
		steady = 1'b0;
		sent = 0;
		settings_used = 1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed walk at reset register values
		issue(FUNC_TICK, 1'b1);      // tick while off
		issue(FUNC_STOP, 1'b1);      // stop while off is ignored
		issue(FUNC_UNUSED, 1'b1);
		issue(FUNC_START, 1'b1);
		issue(FUNC_START, 1'b0);     // second start while pending
		issue(FUNC_TICK, 1'b1);      // attack
		issue(FUNC_UNUSED, 1'b0);
		issue(FUNC_TICK, 1'b0);      // saturates into decay
		issue(FUNC_TICK, 1'b1);      // decay to sustain
		issue(FUNC_TICK, 1'b0);
		issue(FUNC_STOP, 1'b0);
		issue(FUNC_STOP, 1'b1);
		issue(FUNC_TICK, 1'b0);      // release with no echo switches off
		issue(FUNC_START, 1'b1);
		issue(FUNC_STOP, 1'b0);      // start with stop pending
		issue(FUNC_TICK, 1'b1);
		issue(FUNC_START, 1'b0);
		issue(FUNC_TICK, 1'b0);
		issue(FUNC_START, 1'b1);     // restart during attack
		issue(FUNC_TICK, 1'b1);
		issue(FUNC_STOP, 1'b1);
		ticks(2);

		// random notes over a run of register settings
		for (int s = 1; s < N_SETTINGS; s++) begin
			case (s)
				1: load_regs(8'h40, 8'hC7, 8'h80, 8'hC0, 8'h10, 8'h10);
				2: load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				3: load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				4: load_regs(8'h80, 8'h80, 8'h00, 8'h80, 8'h40, 8'h00);
				5: load_regs(8'hFF, 8'h40, 8'h00, 8'h00, 8'h00, 8'h10);
				default: load_regs(any_byte(), any_byte(), any_byte(), any_byte(),
					any_byte(), any_byte());
			endcase
			steady = (s == 3) || ($urandom_range(0, 3) == 0);
			start_count = sent;
			full = 1'b1;
			while (sent - start_count < PHASE_ITEMS) begin
				case (full ? 0 : $urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: begin
						// whole note: start, hold, stop, then the tail
						issue(FUNC_START, 1'($urandom_range(0, 1)));
						ticks(full ? 20 : $urandom_range(0, 30));
						if ($urandom_range(0, 15) == 0)
							drain();
						issue(FUNC_STOP, 1'($urandom_range(0, 1)));
						hold = (full || $urandom_range(0, 7) == 0) ? LONG_TAIL : SHORT_TAIL;
						while (tracker.sounding() && hold > 0) begin
							ticks(1);
							hold--;
						end
					end
					7, 8: begin
						// broken sequences
						case ($urandom_range(0, 3))
							0: begin
								issue(FUNC_START, 1'($urandom_range(0, 1)));
								issue(FUNC_STOP, 1'($urandom_range(0, 1)));
								ticks(1);
							end
							1: begin
								issue(FUNC_START, 1'($urandom_range(0, 1)));
								ticks($urandom_range(0, 6));
								issue(FUNC_START, 1'($urandom_range(0, 1)));
								ticks($urandom_range(0, 10));
							end
							2: begin
								issue(FUNC_STOP, 1'($urandom_range(0, 1)));
								issue(FUNC_STOP, 1'($urandom_range(0, 1)));
								ticks(2);
							end
							default: begin
								issue(FUNC_START, 1'($urandom_range(0, 1)));
								ticks(1);
								issue(FUNC_UNUSED, 1'($urandom_range(0, 1)));
								issue(FUNC_STOP, 1'($urandom_range(0, 1)));
								issue(FUNC_UNUSED, 1'($urandom_range(0, 1)));
								ticks(1);
							end
						endcase
					end
					default: begin
						// noise: any request code
						repeat ($urandom_range(1, 8))
							issue(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
					end
				endcase
				full = 1'b0;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("%0d requests sent across %0d register settings, %0d results compared",
			sent, settings_used, tracker.compared);
		$display("reported phases reached (one bit per phase): %b, mismatches: %0d",
			tracker.phases_seen[6:0], tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hdl/adsr_pkg.sv
hdl/adsr_if.sv
hdl/adsr_regs.sv
hdl/adsr_core.sv
hdl/adsr_envelope_with_echo_tail.sv
sim/adsr_envelope_with_echo_tail_test.sv
